@@ hw/rtl/dsd_pkg.sv @@
// ----------------------------------------------------------------------------
// Dictionary substitution decoder package
// Shared sizes, register indexes, status codes and dictionary port types.
// ----------------------------------------------------------------------------
package dsd_pkg;

	localparam int DSD_DICT_DEPTH  = 128;
	localparam int DSD_TOKEN_BYTES = 64;

	localparam logic [1:0] REG_ESCAPE_BYTE    = 2'd0;
	localparam logic [1:0] REG_LITERAL_MARKER = 2'd1;
	localparam logic [1:0] REG_ENTRIES_IN_USE = 2'd2;

	localparam logic [7:0] ESCAPE_BYTE_RST    = 8'd1;
	localparam logic [7:0] LITERAL_MARKER_RST = 8'd255;
	localparam logic [7:0] ENTRIES_IN_USE_RST = 8'd0;

	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_TRUNC = 2'd1;
	localparam logic [1:0] STAT_RANGE = 2'd2;

	typedef struct packed {
		logic       len_we;
		logic       byte_we;
		logic [7:0] entry;
		logic [5:0] pos;
		logic [5:0] len;
		logic [7:0] data;
	} dsd_wr_t;

	typedef struct packed {
		logic       len_re;
		logic       tok_re;
		logic [7:0] entry;
		logic [5:0] pos;
	} dsd_rd_t;

endpackage

@@ hw/rtl/dictionary_substitution_decoder.sv @@
// Plain, literal and error results: ready in the output register the cycle after transfer.
// Token reference: the length is read first (ST_LEN), then one byte per cycle from the token
// memory read port while the output drains; the input is held until the last byte is loaded.
// Input is taken only when the sequencer is idle and the output register is free or
// draining. Reset clears escape, drop and handshake state and loads the configuration
// registers with their defaults; the dictionary memories are not cleared.
// ----------------------------------------------------------------------------
// Dictionary substitution decoder
// Escape-coded byte stream decoder that expands references from a loaded
// dictionary through a byte-serial read sequencer.
// ----------------------------------------------------------------------------
module dictionary_substitution_decoder import dsd_pkg::*; #(
	parameter int DICT_DEPTH  = DSD_DICT_DEPTH,
	parameter int TOKEN_BYTES = DSD_TOKEN_BYTES
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_write,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       action,
	input  logic [7:0] data_byte,
	input  logic [6:0] entry_index,
	input  logic [5:0] char_position,
	input  logic [5:0] entry_length,
	input  logic       last,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic [1:0] status,
	output logic       run_end,
	output logic       block_end
);

	localparam int CNT_W = $clog2(TOKEN_BYTES + 1);
	localparam int POS_W = $clog2(TOKEN_BYTES);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LEN,
		ST_TOK
	} state_t;

	state_t           state_q;
	logic [7:0]       escape_q;
	logic [7:0]       literal_q;
	logic [7:0]       entries_q;
	logic             pending_q;
	logic             dropping_q;
	logic [7:0]       id_q;
	logic             last_q;
	logic [POS_W-1:0] k_q;
	logic [CNT_W-1:0] n_q;
	logic             out_valid_q;
	logic [7:0]       out_byte_q;
	logic [1:0]       status_q;
	logic             run_end_q;
	logic             block_end_q;

	dsd_wr_t          wr;
	dsd_rd_t          rd;
	logic [5:0]       len_rd;
	logic [7:0]       tok_rd;

	logic             in_acc;
	logic             out_free;
	logic             out_load;
	logic             id_ok;
	logic [CNT_W-1:0] len_n;
	logic [CNT_W-1:0] k_next;
	logic             tok_last;

	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == ST_IDLE) && out_free;
	assign in_acc   = in_valid && in_ready;

	assign id_ok    = (data_byte < entries_q) && (9'(data_byte) < 9'(DICT_DEPTH));
	assign len_n    = (32'(len_rd) > 32'(TOKEN_BYTES)) ? CNT_W'(TOKEN_BYTES) : CNT_W'(len_rd);
	assign k_next   = CNT_W'(k_q) + CNT_W'(1);
	assign tok_last = (k_next == n_q);

	assign out_load = (state_q == ST_TOK) ? out_free
		: ((state_q == ST_IDLE) && in_acc && !action && !dropping_q
			&& (pending_q ? ((data_byte == literal_q) || !id_ok)
				: ((data_byte != escape_q) || last)));

	always_comb begin
		wr.len_we  = in_acc && action && (9'({1'b0, entry_index}) < 9'(DICT_DEPTH));
		wr.byte_we = wr.len_we && (32'(char_position) < 32'(TOKEN_BYTES));
		wr.entry   = {1'b0, entry_index};
		wr.pos     = char_position;
		wr.len     = entry_length;
		wr.data    = data_byte;
	end

	always_comb begin
		rd.len_re = in_acc && !action && !dropping_q && pending_q
			&& (data_byte != literal_q) && id_ok;
		rd.tok_re = ((state_q == ST_LEN) && (len_n != '0))
			|| ((state_q == ST_TOK) && out_free && !tok_last);
		rd.entry  = (state_q == ST_IDLE) ? data_byte : id_q;
		rd.pos    = (state_q == ST_LEN) ? 6'd0 : 6'(k_next);
	end

	dsd_dict #(
		.DICT_DEPTH (DICT_DEPTH),
		.TOKEN_BYTES(TOKEN_BYTES)
	) u_dict (
		.clk   (clk),
		.wr    (wr),
		.rd    (rd),
		.len_rd(len_rd),
		.tok_rd(tok_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			escape_q    <= ESCAPE_BYTE_RST;
			literal_q   <= LITERAL_MARKER_RST;
			entries_q   <= ENTRIES_IN_USE_RST;
			pending_q   <= 1'b0;
			dropping_q  <= 1'b0;
			id_q        <= '0;
			last_q      <= 1'b0;
			k_q         <= '0;
			n_q         <= '0;
			out_valid_q <= 1'b0;
			out_byte_q  <= '0;
			status_q    <= STAT_OK;
			run_end_q   <= 1'b0;
			block_end_q <= 1'b0;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					REG_ESCAPE_BYTE:    escape_q  <= cfg_data;
					REG_LITERAL_MARKER: literal_q <= cfg_data;
					REG_ENTRIES_IN_USE: entries_q <= cfg_data;
					default: ;
				endcase
			end

			// drop the held result once taken
			if (out_valid_q && out_ready && !out_load) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_acc && !action) begin
						if (dropping_q) begin
							if (last) begin
								dropping_q <= 1'b0;
								pending_q  <= 1'b0;
							end
						end else if (pending_q) begin
							pending_q <= 1'b0;
							if (data_byte == literal_q) begin
								out_valid_q <= 1'b1;
								out_byte_q  <= escape_q;
								status_q    <= STAT_OK;
								run_end_q   <= 1'b1;
								block_end_q <= last;
							end else if (id_ok) begin
								id_q    <= data_byte;
								last_q  <= last;
								state_q <= ST_LEN;
							end else begin
								out_valid_q <= 1'b1;
								out_byte_q  <= '0;
								status_q    <= STAT_RANGE;
								run_end_q   <= 1'b1;
								block_end_q <= 1'b1;
								dropping_q  <= !last;
							end
						end else if (data_byte == escape_q) begin
							if (last) begin
								out_valid_q <= 1'b1;
								out_byte_q  <= '0;
								status_q    <= STAT_TRUNC;
								run_end_q   <= 1'b1;
								block_end_q <= 1'b1;
							end else begin
								pending_q <= 1'b1;
							end
						end else begin
							out_valid_q <= 1'b1;
							out_byte_q  <= data_byte;
							status_q    <= STAT_OK;
							run_end_q   <= 1'b1;
							block_end_q <= last;
						end
					end
				end
				ST_LEN: begin
					n_q     <= len_n;
					k_q     <= '0;
					state_q <= (len_n == '0) ? ST_IDLE : ST_TOK;
				end
				ST_TOK: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_byte_q  <= tok_rd;
						status_q    <= STAT_OK;
						run_end_q   <= tok_last;
						block_end_q <= tok_last && last_q;
						if (tok_last) begin
							state_q <= ST_IDLE;
						end else begin
							k_q <= k_next[POS_W-1:0];
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign status    = status_q;
	assign run_end   = run_end_q;
	assign block_end = block_end_q;

	a_err_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (status_q != STAT_OK)
		|-> (out_byte_q == 8'd0) && run_end_q && block_end_q)
		else $error("error result without zero byte and end marks");

	a_block_end_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && block_end_q |-> run_end_q)
		else $error("block end without run end");

	a_tok_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_TOK) |-> (CNT_W'(k_q) < n_q))
		else $error("token byte counter past entry length");

	a_pend_drop: assert property (@(posedge clk) disable iff (!arst_n)
		!(pending_q && dropping_q))
		else $error("escape pending while dropping");

endmodule

@@ hw/rtl/dsd_dict.sv @@
// ----------------------------------------------------------------------------
// Dictionary storage
// Token byte memory and entry length memory, one write and one registered
// read of each per cycle.
// ----------------------------------------------------------------------------
module dsd_dict import dsd_pkg::*; #(
	parameter int DICT_DEPTH  = DSD_DICT_DEPTH,
	parameter int TOKEN_BYTES = DSD_TOKEN_BYTES
) (
	input  logic       clk,
	input  dsd_wr_t    wr,
	input  dsd_rd_t    rd,
	output logic [5:0] len_rd,
	output logic [7:0] tok_rd
);

	localparam int IDX_W       = (DICT_DEPTH > 1) ? $clog2(DICT_DEPTH) : 1;
	localparam int POS_W       = $clog2(TOKEN_BYTES);
	localparam int STORE_DEPTH = DICT_DEPTH << POS_W;

	logic [7:0] tok_mem [STORE_DEPTH];
	logic [5:0] len_mem [DICT_DEPTH];

	logic [IDX_W+POS_W-1:0] wr_addr;
	logic [IDX_W+POS_W-1:0] rd_addr;

	assign wr_addr = {wr.entry[IDX_W-1:0], wr.pos[POS_W-1:0]};
	assign rd_addr = {rd.entry[IDX_W-1:0], rd.pos[POS_W-1:0]};

	always_ff @(posedge clk) begin
		if (wr.byte_we) begin
			tok_mem[wr_addr] <= wr.data;
		end
		if (rd.tok_re) begin
			tok_rd <= tok_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (wr.len_we) begin
			len_mem[wr.entry[IDX_W-1:0]] <= wr.len;
		end
		if (rd.len_re) begin
			len_rd <= len_mem[rd.entry[IDX_W-1:0]];
		end
	end

endmodule
